>>> rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int PATTERN_BYTES = 16;
  localparam int ADDRESS_BITS  = 32;

  localparam int LEN_W   = 5;
  localparam int WIN_W   = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int PB_W    = $clog2(PATTERN_BYTES + 1);
  localparam int CNT_W   = (PB_W > LEN_W) ? PB_W : LEN_W;
  localparam int POS_W   = 32;
  localparam int MCNT_W  = 16;
  localparam int OADDR_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(16);
  localparam logic [MCNT_W-1:0] LIMIT_RESET = '1;
  localparam logic [POS_W-1:0]  POS_MAX     = '1;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_MATCH_LIMIT    = 3'd4,
    REG_BASE_ADDRESS   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [63:0]        pattern_low;
    logic [63:0]        pattern_high;
    logic [15:0]        wildcard_mask;
    logic [LEN_W-1:0]   pattern_length;
    logic [MCNT_W-1:0]  match_limit;
    logic [31:0]        base_address;
  } cfg_t;

  // one queue entry: what an item leaves for the back end
  typedef struct packed {
    logic               has_match;
    logic               has_end;
    logic [POS_W-1:0]   offset;
    logic [MCNT_W-1:0]  count;
  } qent_t;

  function automatic logic [7:0] pat_byte(input cfg_t c, input int i);
    logic [7:0] b;
    b = 8'h00;
    if (i < 8) begin
      b = c.pattern_low[8*i +: 8];
    end else if (i < 16) begin
      b = c.pattern_high[8*(i-8) +: 8];
    end
    return b;
  endfunction

  function automatic logic pat_wild(input cfg_t c, input int i);
    logic w;
    w = 1'b0;
    if (i < 16) begin
      w = c.wildcard_mask[i];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mbps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, data_byte, region_end, input ready);
  modport sink   (input valid, data_byte, region_end, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] match_address;
  logic [15:0] match_count;
  logic        last_result;

  modport source (output valid, result_kind, match_address, match_count, last_result,
                  input ready);
  modport sink   (input valid, result_kind, match_address, match_count, last_result,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/mbps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_PATTERN_LOW:    cfg_nxt.pattern_low    = pwdata;
        REG_PATTERN_HIGH:   cfg_nxt.pattern_high   = pwdata;
        REG_WILDCARD_MASK:  cfg_nxt.wildcard_mask  = pwdata[15:0];
        REG_PATTERN_LENGTH: cfg_nxt.pattern_length = pwdata[LEN_W-1:0];
        REG_MATCH_LIMIT:    cfg_nxt.match_limit    = pwdata[MCNT_W-1:0];
        REG_BASE_ADDRESS:   cfg_nxt.base_address   = pwdata[31:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LOW:    prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH:   prdata = cfg_r.pattern_high;
      REG_WILDCARD_MASK:  prdata = CFG_DW'(cfg_r.wildcard_mask);
      REG_PATTERN_LENGTH: prdata = CFG_DW'(cfg_r.pattern_length);
      REG_MATCH_LIMIT:    prdata = CFG_DW'(cfg_r.match_limit);
      REG_BASE_ADDRESS:   prdata = CFG_DW'(cfg_r.base_address);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.wildcard_mask  <= '0;
      cfg_r.pattern_length <= LEN_RESET;
      cfg_r.match_limit    <= LIMIT_RESET;
      cfg_r.base_address   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mbps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_front
  import mbps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mbps_in_if.sink   in_ch,
  input  wire cfg_t cfg,
  input  wire logic q_full,
  output      logic q_push,
  output      qent_t q_wdata
);

  logic [PATTERN_BYTES-1:0][7:0] win_r;
  logic [PATTERN_BYTES-1:0][7:0] win_shift;
  logic [PATTERN_BYTES-1:0][7:0] win_nxt;
  logic [POS_W-1:0]              pos_r;
  logic [POS_W-1:0]              pos_inc;
  logic [POS_W-1:0]              pos_nxt;
  logic [MCNT_W-1:0]             found_r;
  logic [MCNT_W-1:0]             found_inc;
  logic [MCNT_W-1:0]             found_nxt;
  logic [CNT_W-1:0]              eff_len;
  logic [CNT_W-1:0]              sel [PATTERN_BYTES];
  logic                          win_eq;
  logic                          hit;
  logic                          accept;
  logic                          is_end;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_end      = in_ch.region_end;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (CNT_W'(cfg.pattern_length) > CNT_W'(PATTERN_BYTES)) begin
      eff_len = CNT_W'(PATTERN_BYTES);
    end else begin
      eff_len = CNT_W'(cfg.pattern_length);
    end
  end

  // newest byte at index 0
  always_comb begin
    win_shift[0] = in_ch.data_byte;
    for (int j = 1; j < PATTERN_BYTES; j++) begin
      win_shift[j] = win_r[j-1];
    end
  end

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);

  // pattern byte i lines up with the byte received eff_len-1-i items ago
  always_comb begin
    win_eq = 1'b1;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      sel[i] = eff_len - CNT_W'(1) - CNT_W'(i);
      if ((CNT_W'(i) < eff_len) && !pat_wild(cfg, i) &&
          (win_shift[sel[i][WIN_W-1:0]] != pat_byte(cfg, i))) begin
        win_eq = 1'b0;
      end
    end
  end

  assign hit       = (pos_inc >= POS_W'(eff_len)) && (found_r < cfg.match_limit) && win_eq;
  assign found_inc = hit ? found_r + MCNT_W'(1) : found_r;

  always_comb begin
    win_nxt   = win_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    if (accept) begin
      if (is_end) begin
        win_nxt   = '0;
        pos_nxt   = '0;
        found_nxt = '0;
      end else begin
        win_nxt   = win_shift;
        pos_nxt   = pos_inc;
        found_nxt = found_inc;
      end
    end
  end

  assign q_push            = accept && (hit || is_end);
  assign q_wdata.has_match = hit;
  assign q_wdata.has_end   = is_end;
  assign q_wdata.offset    = pos_inc - POS_W'(eff_len);
  assign q_wdata.count     = found_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      pos_r   <= '0;
      found_r <= '0;
    end else begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
    end
  end

`ifndef SYNTHESIS
  a_found_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hit) |-> (found_inc <= cfg.match_limit && found_inc != '0))
    else $error("match count passed the limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_end) |=> (pos_r == '0 && found_r == '0))
    else $error("region end did not clear the scan state");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mbps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_fifo
  import mbps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t wdata,
  output      logic  full,
  input  wire logic  pop,
  output      logic  not_empty,
  output      qent_t rdata
);

  qent_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r;
  logic [FIFO_AW:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == (FIFO_AW+1)'(FIFO_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + (FIFO_AW+1)'(1)))
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mbps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_back
  import mbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] base_address,
  input  wire logic        q_not_empty,
  input  wire qent_t       q_rdata,
  output      logic        q_pop,
  mbps_out_if.source       out_ch
);

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  result_kind_t         kind_r;
  result_kind_t         kind_nxt;
  logic [OADDR_W-1:0]   addr_r;
  logic [OADDR_W-1:0]   addr_nxt;
  logic [MCNT_W-1:0]    count_r;
  logic [MCNT_W-1:0]    count_nxt;
  logic                 last_r;
  logic                 last_nxt;
  logic                 phase_r;
  logic                 phase_nxt;
  logic                 load;
  logic                 emit_match;
  logic [ADDRESS_BITS-1:0] full_addr;

  assign load       = q_not_empty && (!out_valid_r || out_ch.ready);
  assign emit_match = q_rdata.has_match && !phase_r;
  assign full_addr  = ADDRESS_BITS'(base_address) + ADDRESS_BITS'(q_rdata.offset);

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      count_nxt     = q_rdata.count;
      if (emit_match) begin
        kind_nxt  = KIND_MATCH;
        addr_nxt  = OADDR_W'(full_addr);
        last_nxt  = !q_rdata.has_end;
        q_pop     = !q_rdata.has_end;
        phase_nxt = q_rdata.has_end;
      end else begin
        kind_nxt  = KIND_SUMMARY;
        addr_nxt  = '0;
        last_nxt  = 1'b1;
        q_pop     = 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.match_address = addr_r;
  assign out_ch.match_count   = count_r;
  assign out_ch.last_result   = last_r;

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_has_end: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (q_not_empty && q_rdata.has_end && q_rdata.has_match))
    else $error("summary pending without a region end entry");

  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_SUMMARY) |-> (addr_r == '0 && last_r))
    else $error("summary result malformed");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_MATCH) |-> (count_r != '0))
    else $error("match result with zero count");

  a_match_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_MATCH && !last_r) |-> phase_r)
    else $error("match not followed by its summary");
`endif

endmodule

`default_nettype wire

>>> rtl/core/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// port     dir   handshake                  payload
// in_ch    sink  valid/ready                data_byte, region_end
// out_ch   src   valid/ready                result_kind, match_address, match_count, last_result
// apb      sink  psel/penable/pwrite/pready paddr (reg i at 8*i), pwdata, prdata
//
// one byte accepted per cycle while the queue is not full; window compare and count update
// finish in the accept cycle; results leave through a registered output one per cycle
// while out_ch is ready; an item that matches and ends its region gives a match then a summary
// a four-entry queue between classifier and result stage absorbs those and output stalls
// synchronous active-low reset: window, position and count cleared, registers to defaults

module masked_byte_pattern_scanner
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  mbps_in_if.sink                in_ch,
  mbps_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_push;
  qent_t q_wdata;
  logic  q_pop;
  logic  q_not_empty;
  qent_t q_rdata;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  mbps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  mbps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_address (cfg.base_address),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/mbps_scan_checker.sv
`timescale 1ns / 1ps

module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mbps_in_if                in_mon,
  mbps_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  addr;
    logic [15:0]  count;
    logic         last;
  } scan_result_t;

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [15:0] wild_mask;
  logic [4:0]  pat_len;
  logic [15:0] limit;
  logic [31:0] base;

  logic [7:0]  window [PATTERN_BYTES];
  logic [31:0] position;
  logic [15:0] found;

  scan_result_t expected_q[$];
  int n_bad = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int active_len();
    if (pat_len == 0) begin
      return 1;
    end
    if (pat_len > PATTERN_BYTES) begin
      return PATTERN_BYTES;
    end
    return int'(pat_len);
  endfunction

  function automatic logic window_hit(input int len);
    logic [7:0] want;
    int i;
    for (i = 0; i < len; i++) begin
      if (i < 8) begin
        want = pat_lo[8*i +: 8];
      end else begin
        want = pat_hi[8*(i-8) +: 8];
      end
      if (!wild_mask[i] && window[len-1-i] != want) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic apply_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    case (addr[CFG_AW-1:3])
      REG_PATTERN_LOW:    pat_lo = data;
      REG_PATTERN_HIGH:   pat_hi = data;
      REG_WILDCARD_MASK:  wild_mask = data[15:0];
      REG_PATTERN_LENGTH: pat_len = data[4:0];
      REG_MATCH_LIMIT:    limit = data[15:0];
      REG_BASE_ADDRESS:   base = data[31:0];
      default: ;
    endcase
  endtask

  task automatic clear_region();
    int i;
    for (i = 0; i < PATTERN_BYTES; i++) begin
      window[i] = 8'h00;
    end
    position = '0;
    found = '0;
  endtask

  task automatic scan_byte(input logic [7:0] data, input logic fin);
    int len;
    int i;
    scan_result_t r;
    len = active_len();
    for (i = PATTERN_BYTES - 1; i > 0; i--) begin
      window[i] = window[i-1];
    end
    window[0] = data;
    if (position != POS_MAX) begin
      position = position + 32'd1;
    end
    if (position >= len && found < limit && window_hit(len)) begin
      found = found + 16'd1;
      r.kind  = KIND_MATCH;
      r.addr  = base + (position - 32'(len));
      r.count = found;
      r.last  = !fin;
      expected_q.push_back(r);
    end
    if (fin) begin
      r.kind  = KIND_SUMMARY;
      r.addr  = '0;
      r.count = found;
      r.last  = 1'b1;
      expected_q.push_back(r);
      clear_region();
    end
  endtask

  task automatic flag_bad(input string what, input scan_result_t want, input scan_result_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t %s: expected kind %0d addr %h count %0d last %0d", $time, what,
               want.kind, want.addr, want.count, want.last);
      $display("%0t %s: actual   kind %0d addr %h count %0d last %0d", $time, what,
               got.kind, got.addr, got.count, got.last);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      pat_lo    = '0;
      pat_hi    = '0;
      wild_mask = '0;
      pat_len   = LEN_RESET;
      limit     = LIMIT_RESET;
      base      = '0;
      clear_region();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr, pwdata);
      end
      if (in_mon.valid && in_mon.ready) begin
        scan_byte(in_mon.data_byte, in_mon.region_end);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind  = result_kind_t'(out_mon.result_kind);
        got.addr  = out_mon.match_address;
        got.count = out_mon.match_count;
        got.last  = out_mon.last_result;
        if (expected_q.size() == 0) begin
          flag_bad("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind || got.addr !== want.addr ||
              got.count !== want.count || got.last !== want.last) begin
            flag_bad("mismatch", want, got);
          end
        end
      end
    end
    fail_count <= n_bad;
    pending <= expected_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mbps_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 37;
  localparam int END_PCT       = 3;
  localparam int PHASE_ITEMS   = 160;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  int cycles = 0;
  int n_sent = 0;
  logic steady = 1'b0;

  logic [63:0] cur_lo;
  logic [63:0] cur_hi;
  logic [15:0] cur_wild;
  int cur_len;

  mbps_in_if in_ch();
  mbps_out_if out_ch();

  masked_byte_pattern_scanner uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbps_scan_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] pattern_byte(input int i);
    if (i < 8) begin
      return cur_lo[8*i +: 8];
    end
    return cur_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic end_roll();
    return $urandom_range(99) < END_PCT;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] wild, input logic [4:0] len,
                            input logic [15:0] lim, input logic [31:0] base);
    reg_write(REG_PATTERN_LOW, lo);
    reg_write(REG_PATTERN_HIGH, hi);
    reg_write(REG_WILDCARD_MASK, 64'(wild));
    reg_write(REG_PATTERN_LENGTH, 64'(len));
    reg_write(REG_MATCH_LIMIT, 64'(lim));
    reg_write(REG_BASE_ADDRESS, 64'(base));
    cur_lo   = lo;
    cur_hi   = hi;
    cur_wild = wild;
    if (len == 0) begin
      cur_len = 1;
    end else if (len > PATTERN_BYTES) begin
      cur_len = PATTERN_BYTES;
    end else begin
      cur_len = int'(len);
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic fin);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (!steady && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.region_end <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly pattern instances with random wildcard bytes, some corrupted, plus noise
  task automatic random_phase();
    int start;
    int k;
    int bad;
    logic [7:0] b;
    start = n_sent;
    while (n_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(99) < 65) begin
        bad = ($urandom_range(99) < 15) ? int'($urandom_range(cur_len - 1)) : -1;
        for (k = 0; k < cur_len; k++) begin
          b = cur_wild[k] ? 8'($urandom) : pattern_byte(k);
          if (k == bad) begin
            b = b ^ 8'($urandom_range(1, 255));
          end
          send_byte(b, end_roll());
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = $urandom_range(1) ? 8'($urandom) : pattern_byte($urandom_range(cur_len - 1));
          send_byte(b, end_roll());
        end
      end
    end
  endtask

  initial begin
    int p;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] wild;
    logic [4:0]  len;
    logic [15:0] lim;
    logic [31:0] base;

    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.region_end = 1'b0;
    out_ch.ready     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length acts as one, addresses wrap past the top
    load_setup(64'hFF, 64'h0, 16'h0000, 5'd0, 16'hFFFF, 32'hFFFF_FFFE);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // oversized length saturates, all bytes wild, limit cuts the third match
    load_setup({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd31, 16'd2,
               32'h0000_1000);
    for (p = 0; p < 18; p++) begin
      send_byte((p % 2) ? 8'hFF : 8'h00, p == 17);
    end
    settle();

    // zero limit, writes to unmapped registers
    load_setup(64'h0, 64'h0, 16'hFFFF, 5'd1, 16'd0, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_A, '1);
    reg_write(REG_SPARE_B, '1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      wild = 16'($urandom & $urandom);
      len  = 5'($urandom_range(1, 16));
      lim  = 16'hFFFF;
      base = $urandom;
      case (p)
        0: begin
          len  = 5'd1;
          wild = '0;
        end
        1: begin
          len  = 5'd16;
          lim  = 16'd1;
          base = '1;
        end
        2: begin
          len = 5'($urandom_range(2, 8));
          lim = 16'($urandom_range(1, 3));
        end
        3: wild = 16'($urandom & $urandom & $urandom);
        4: begin
          len  = 5'd16;
          wild = '1;
          lim  = 16'($urandom_range(1, 5));
        end
        5: lim = '0;
        6: len = 5'($urandom_range(17, 31));
        default: ;
      endcase
      steady <= (p == 3);
      load_setup(lo, hi, wild, len, lim, base);
      random_phase();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
